/* rtl/umst_pkg.sv */
`timescale 1ns / 1ps

package umst_pkg;

  typedef struct packed {
    logic [47:0]        mac;
    logic signed [7:0]  strength;
    logic [31:0]        epoch;
    logic [1:0]         kind;
    logic [3:0]         subkind;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic stronger;
  } cmp_t;

  typedef logic [2:0] status_t;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_UPDATED   = 3'd1;
  localparam status_t ST_UNCHANGED = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_DUMP      = 3'd4;

  localparam int TOTAL_W = 7;

endpackage

/* rtl/umst_if.sv */
`timescale 1ns / 1ps

interface umst_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [47:0]        mac;
  logic signed [7:0]  signal_strength;
  logic [31:0]        epoch_stamp;
  logic [1:0]         frame_kind;
  logic [3:0]         frame_subkind;

  modport source (
    output valid, op, mac, signal_strength, epoch_stamp, frame_kind, frame_subkind,
    input  ready
  );
  modport sink (
    input  valid, op, mac, signal_strength, epoch_stamp, frame_kind, frame_subkind,
    output ready
  );
endinterface

interface umst_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [6:0]         unique_total;
  logic [47:0]        out_mac;
  logic signed [7:0]  out_strength;
  logic [31:0]        out_epoch;
  logic [1:0]         out_kind;
  logic [3:0]         out_subkind;
  logic               last;

  modport source (
    output valid, status, unique_total, out_mac, out_strength, out_epoch, out_kind,
           out_subkind, last,
    input  ready
  );
  modport sink (
    input  valid, status, unique_total, out_mac, out_strength, out_epoch, out_kind,
           out_subkind, last,
    output ready
  );
endinterface

/* rtl/umst_store.sv */
`timescale 1ns / 1ps

module umst_store #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output umst_pkg::entry_t     rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  umst_pkg::entry_t     wr_data
);

  umst_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/umst_cmp.sv */
`timescale 1ns / 1ps

module umst_cmp (
  input  logic               pend,
  input  logic [47:0]        key_mac,
  input  logic signed [7:0]  key_strength,
  input  umst_pkg::entry_t   entry,
  output umst_pkg::cmp_t     result
);

  always_comb begin
    result.hit      = pend && (entry.mac == key_mac);
    result.stronger = key_strength > entry.strength;
  end

endmodule

/* rtl/unique_mac_strongest_signal_table.sv */
`timescale 1ns / 1ps
// Observe: the item is taken in S_IDLE, then one stored entry compared per cycle against it;
//   a hit ends the scan early, else it runs to the last entry (N = stored entries). The word
//   is then loaded into the output register once that is free; an empty table inserts at once.
// Dump: each entry read on the single read port, then loaded when output is free; empty: none.
// One item at a time; the next item is taken while the last word still waits at the output.
// rst (synchronous) clears the sequencer, entry count and output valid; table RAM is not cleared.
module unique_mac_strongest_signal_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  umst_req_if.sink        req,
  umst_rsp_if.source      rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_RESP = 5'b00100,
    S_DRD  = 5'b01000,
    S_DLD  = 5'b10000
  } state_t;

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         idx, idx_next;
  logic                  pend, pend_next;
  logic [AW-1:0]         pidx;
  umst_pkg::entry_t      key;
  umst_pkg::status_t     res_status, res_status_next;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  umst_pkg::entry_t      rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  umst_pkg::entry_t      wr_data;
  umst_pkg::cmp_t        cmp;

  logic                  o_valid;
  umst_pkg::status_t     o_status;
  logic [umst_pkg::TOTAL_W-1:0] o_total;
  umst_pkg::entry_t      o_entry;
  logic                  o_last;

  logic                  o_free;
  logic                  load;
  umst_pkg::status_t     load_status;
  logic [umst_pkg::TOTAL_W-1:0] load_total;
  umst_pkg::entry_t      load_entry;
  logic                  load_last;
  logic                  accept;

  umst_store #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  umst_cmp u_cmp (
    .pend         (pend),
    .key_mac      (key.mac),
    .key_strength (key.strength),
    .entry        (rd_data),
    .result       (cmp)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign o_free    = !o_valid || rsp.ready;

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    pend_next       = 1'b0;
    res_status_next = res_status;
    rd_en           = 1'b0;
    rd_addr         = idx[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = pidx;
    wr_data         = key;
    load            = 1'b0;
    load_status     = umst_pkg::ST_DUMP;
    load_total      = '0;
    load_entry      = '0;
    load_last       = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next = '0;
          if (req.op) begin
            if (count != '0) begin
              state_next = S_DRD;
            end
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en     = (idx < count);
        pend_next = rd_en;
        if (rd_en) begin
          idx_next = idx + CW'(1);
        end
        if (cmp.hit) begin
          if (cmp.stronger) begin
            wr_en           = 1'b1;
            wr_data         = rd_data;
            wr_data.strength = key.strength;
            wr_data.epoch   = key.epoch;
            res_status_next = umst_pkg::ST_UPDATED;
          end else begin
            res_status_next = umst_pkg::ST_UNCHANGED;
          end
          state_next = S_RESP;
        end else if (!pend && (idx >= count)) begin
          if (count < CW'(TABLE_DEPTH)) begin
            wr_en           = 1'b1;
            wr_addr         = count[AW-1:0];
            count_next      = count + CW'(1);
            res_status_next = umst_pkg::ST_INSERTED;
          end else begin
            res_status_next = umst_pkg::ST_FULL;
          end
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (o_free) begin
          load        = 1'b1;
          load_status = res_status;
          load_total  = umst_pkg::TOTAL_W'(count);
          state_next  = S_IDLE;
        end
      end
      S_DRD: begin
        rd_en      = 1'b1;
        state_next = S_DLD;
      end
      S_DLD: begin
        if (o_free) begin
          load       = 1'b1;
          load_entry = rd_data;
          load_last  = ((idx + CW'(1)) == count);
          if (load_last) begin
            count_next = '0;
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = S_DRD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      pend    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      pend    <= pend_next;
      if (load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    pidx       <= idx[AW-1:0];
    res_status <= res_status_next;
    if (accept) begin
      key.mac      <= req.mac;
      key.strength <= req.signal_strength;
      key.epoch    <= req.epoch_stamp;
      key.kind     <= req.frame_kind;
      key.subkind  <= req.frame_subkind;
    end
    if (load) begin
      o_status <= load_status;
      o_total  <= load_total;
      o_entry  <= load_entry;
      o_last   <= load_last;
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.status       = o_status;
  assign rsp.unique_total = o_total;
  assign rsp.out_mac      = o_entry.mac;
  assign rsp.out_strength = o_entry.strength;
  assign rsp.out_epoch    = o_entry.epoch;
  assign rsp.out_kind     = o_entry.kind;
  assign rsp.out_subkind  = o_entry.subkind;
  assign rsp.last         = o_last;

endmodule

/* rtl/umst_check.sv */
`timescale 1ns / 1ps

module umst_check #(
  parameter int TABLE_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [6:0]  unique_total,
  input logic [47:0] out_mac,
  input logic        last
);

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (unique_total <= 7'(TABLE_DEPTH)))
    else $error("unique_total above table depth");

  a_dump_total: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == umst_pkg::ST_DUMP)) |-> (unique_total == '0))
    else $error("dump word with non-zero total");

  a_observe_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != umst_pkg::ST_DUMP)) |-> (last && (out_mac == '0)))
    else $error("observe word not single or carries entry data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output word dropped while stalled");

endmodule

bind unique_mac_strongest_signal_table umst_check #(.TABLE_DEPTH(TABLE_DEPTH)) u_check (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .status       (rsp.status),
  .unique_total (rsp.unique_total),
  .out_mac      (rsp.out_mac),
  .last         (rsp.last)
);
